// File: rtl/jhd_pkg.sv
`default_nettype none
package jhd_pkg;
  localparam logic [1:0] FUNC_COUNT   = 2'd0;
  localparam logic [1:0] FUNC_SYMBOL  = 2'd1;
  localparam logic [1:0] FUNC_DATA    = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  localparam logic [1:0] PH_DC_CODE = 2'd0;
  localparam logic [1:0] PH_DC_MAG  = 2'd1;
  localparam logic [1:0] PH_AC_CODE = 2'd2;
  localparam logic [1:0] PH_AC_MAG  = 2'd3;

  localparam int MAX_CODE_LEN = 16;
  localparam int BLOCK_COEFFS = 64;

  typedef struct packed {
    logic [5:0]  position;
    logic [15:0] coefficient;
    logic        end_of_block;
    logic        code_error;
  } result_t;

  // sign-extend a JPEG magnitude of the given size
  function automatic logic [15:0] extend_value(input logic [15:0] bits,
                                               input logic [3:0] size);
    logic [15:0] lim;
    logic        top;
    begin
      lim = 16'((17'd1 << size) - 17'd1);
      top = bits[4'(size - 4'd1)];
      extend_value = top ? bits : 16'(bits - lim);
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/jpeg_huffman_block_decoder_core.sv
`default_nettype none
// JPEG baseline Huffman block decoder.
// Input channel (valid/ready): func selects code-count load, symbol load,
// coded data byte or predictor/block restart. Loads, restarts and a zero
// byte following 0xFF are taken without leaving idle, back to back.
// A data byte is shifted in one bit per cycle (held while a result waits
// or a symbol is read and applied) through a shared compare/lookup unit
// against the code-limit tables: accept, bit steps, a symbol RAM read and
// apply for each decoded symbol, and a move into the output register for
// each result. Ready stays low until the byte is done and its last result
// has moved. Output channel (valid/ready): position, coefficient,
// end_of_block and code_error; one registered result plus one waiting
// behind it. While the receiver stalls, a second result waits and the bit
// sequencer stops until it moves into the output register.
// Reset clears the code limits (all lengths empty), the predictor and the
// block state. Symbol storage is undefined until loaded.
module jpeg_huffman_block_decoder_core #(
  parameter int SYMBOL_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic        table_class,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       position,
  output logic signed [15:0] coefficient,
  output logic             end_of_block,
  output logic             code_error
);
  import jhd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BIT  = 2'd1;
  localparam logic [1:0] S_SYM  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]  state;
  logic [7:0]  shreg;
  logic [2:0]  bitcnt;
  logic        after_ff;
  logic [15:0] dc_predictor;
  logic [15:0] code_so_far;
  logic [4:0]  code_length;
  logic [3:0]  magnitude_size;
  logic [15:0] magnitude_bits;
  logic [6:0]  block_position;
  logic [1:0]  decode_phase;
  logic [8:0]  sym_addr;
  logic        res_pend;
  result_t     res;

  logic        acc;
  assign acc = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && !res_pend;

  // output register
  logic        ov;
  result_t     oreg;
  assign out_valid = ov;
  assign position = oreg.position;
  assign coefficient = oreg.coefficient;
  assign end_of_block = oreg.end_of_block;
  assign code_error = oreg.code_error;

  // tables
  logic        is_ac;
  logic [16:0] lk_max;
  logic [15:0] lk_min;
  logic [7:0]  lk_off;
  logic [15:0] cs_n;
  logic [4:0]  cl_n;
  assign is_ac = (decode_phase == PH_AC_CODE);
  assign cs_n = {code_so_far[14:0], shreg[7]};
  assign cl_n = code_length + 5'd1;

  jhd_tables u_tab (
    .clk(clk), .rst(rst),
    .load(acc && func == FUNC_COUNT && entry_index < 8'd16),
    .cls(table_class), .idx(entry_index[3:0]), .count(value),
    .lk_cls(is_ac), .lk_len(4'(cl_n - 5'd1)),
    .lk_max(lk_max), .lk_min(lk_min), .lk_off(lk_off)
  );

  logic [7:0] sym;
  jhd_ram #(.WIDTH(8), .DEPTH(512)) u_sym (
    .clk(clk),
    .we(acc && func == FUNC_SYMBOL && 9'(entry_index) < 9'(SYMBOL_SLOTS)),
    .waddr({table_class, entry_index}), .wdata(value),
    .raddr(sym_addr), .rdata(sym)
  );

  logic [15:0] mb_n;
  logic [15:0] ext;
  logic [15:0] dc_sum;
  assign mb_n = {magnitude_bits[14:0], shreg[7]};
  assign ext = extend_value(mb_n, magnitude_size);
  assign dc_sum = dc_predictor + ext;
  logic        code_ph;
  assign code_ph = (decode_phase == PH_DC_CODE) || (decode_phase == PH_AC_CODE);
  // an empty length holds all ones, which reads as -1 here
  logic        over;
  assign over = $signed({1'b0, cs_n}) > $signed(lk_max);
  logic [7:0]  slot;
  assign slot = 8'(lk_off + cs_n[7:0] - lk_min[7:0]);
  logic [3:0]  run;
  logic [3:0]  sz;
  logic [6:0]  bp_run;
  logic [6:0]  bp_16;
  assign run = sym[7:4];
  assign sz = sym[3:0];
  assign bp_run = block_position + 7'(run);
  assign bp_16 = block_position + 7'd16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after_ff <= 1'b0;
      dc_predictor <= '0;
      code_so_far <= '0;
      code_length <= '0;
      magnitude_size <= '0;
      magnitude_bits <= '0;
      block_position <= '0;
      decode_phase <= PH_DC_CODE;
      res_pend <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (res_pend && (!ov || out_ready)) begin
        oreg <= res;
        ov <= 1'b1;
        res_pend <= 1'b0;
      end else if (ov && out_ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (func == FUNC_RESTART) begin
              dc_predictor <= '0;
              after_ff <= 1'b0;
              block_position <= '0; decode_phase <= PH_DC_CODE;
              code_so_far <= '0; code_length <= '0;
              magnitude_size <= '0; magnitude_bits <= '0;
            end else if (func == FUNC_DATA) begin
              after_ff <= (value == 8'hFF) && !(after_ff && value == 8'h00);
              if (!(after_ff && value == 8'h00)) begin
                shreg <= value;
                bitcnt <= 3'd0;
                state <= S_BIT;
              end
            end
          end
        end
        S_BIT: begin
          if (!res_pend) begin
            if (code_ph) begin
              if (cl_n > 5'd16 || cl_n == 5'd0 || (over && cl_n >= 5'd16)) begin
                res <= '{6'd0, 16'd0, 1'b1, 1'b1};
                res_pend <= 1'b1;
                block_position <= '0; decode_phase <= PH_DC_CODE;
                code_so_far <= '0; code_length <= '0;
                magnitude_size <= '0; magnitude_bits <= '0;
              end else if (over) begin
                code_so_far <= cs_n;
                code_length <= cl_n;
              end else begin
                sym_addr <= {is_ac, slot};
                code_so_far <= '0; code_length <= '0; magnitude_bits <= '0;
                state <= S_SYM;
              end
            end else begin
              if (cl_n >= 5'(magnitude_size)) begin
                code_length <= '0;
                magnitude_bits <= '0;
                if (decode_phase == PH_DC_MAG) begin
                  dc_predictor <= dc_sum;
                  decode_phase <= PH_AC_CODE;
                  block_position <= 7'd1;
                  res <= '{6'd0, dc_sum, 1'b0, 1'b0};
                end else if (block_position + 7'd1 >= 7'(BLOCK_COEFFS)) begin
                  res <= '{block_position[5:0], ext, 1'b1, 1'b0};
                  block_position <= '0; decode_phase <= PH_DC_CODE;
                  magnitude_size <= '0;
                end else begin
                  res <= '{block_position[5:0], ext, 1'b0, 1'b0};
                  block_position <= block_position + 7'd1;
                  decode_phase <= PH_AC_CODE;
                end
                res_pend <= 1'b1;
              end else begin
                magnitude_bits <= mb_n;
                code_length <= cl_n;
              end
            end
            if (state == S_BIT) begin
              shreg <= {shreg[6:0], 1'b0};
              bitcnt <= bitcnt + 3'd1;
              if (!(code_ph && !(cl_n > 5'd16 || cl_n == 5'd0) && !over)
                  && bitcnt == 3'd7)
                state <= S_IDLE;
            end
          end
        end
        S_SYM: state <= S_APPLY;
        S_APPLY: begin
          if (!res_pend) begin
            state <= (bitcnt == 3'd0) ? S_IDLE : S_BIT;
            if (decode_phase == PH_DC_CODE) begin
              magnitude_size <= sz;
              if (sz == 4'd0) begin
                decode_phase <= PH_AC_CODE;
                block_position <= 7'd1;
                res <= '{6'd0, dc_predictor, 1'b0, 1'b0};
                res_pend <= 1'b1;
              end else begin
                decode_phase <= PH_DC_MAG;
              end
            end else if (sz != 4'd0) begin
              if (bp_run >= 7'(BLOCK_COEFFS)) begin
                res <= '{6'd0, 16'd0, 1'b1, 1'b0};
                res_pend <= 1'b1;
                block_position <= '0; decode_phase <= PH_DC_CODE;
                magnitude_size <= '0;
              end else begin
                block_position <= bp_run;
                magnitude_size <= sz;
                decode_phase <= PH_AC_MAG;
              end
            end else if (run == 4'd15 && bp_16 < 7'(BLOCK_COEFFS)) begin
              block_position <= bp_16;
            end else begin
              res <= '{6'd0, 16'd0, 1'b1, 1'b0};
              res_pend <= 1'b1;
              block_position <= '0; decode_phase <= PH_DC_CODE;
              magnitude_size <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/jhd_ram.sv
`default_nettype none
module jhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/jhd_tables.sv
`default_nettype none
// Code-limit tables: built from counts, looked up per (class, length).
module jhd_tables (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic       cls,
  input  wire logic [3:0] idx,
  input  wire logic [7:0] count,
  input  wire logic       lk_cls,
  input  wire logic [3:0] lk_len,
  output logic [16:0]     lk_max,
  output logic [15:0]     lk_min,
  output logic [7:0]      lk_off
);
  logic [16:0] max_code [32];
  logic [15:0] min_code [32];
  logic [7:0]  value_offset [32];
  logic [16:0] build_code [2];
  logic [8:0]  build_offset [2];
  logic [16:0] bc;
  logic [8:0]  bo;
  logic [17:0] last;
  logic [4:0]  we_e;

  assign bc   = (idx == 4'd0) ? 17'd0 : build_code[cls];
  assign bo   = (idx == 4'd0) ? 9'd0 : build_offset[cls];
  // one bit wider than the build code so the saturation sees every carry
  assign last = 18'(bc) + 18'(count) - 18'd1;
  assign we_e = {cls, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        max_code[i] <= '1;
        min_code[i] <= '0;
        value_offset[i] <= '0;
      end
      build_code[0] <= '0; build_code[1] <= '0;
      build_offset[0] <= '0; build_offset[1] <= '0;
    end else if (load) begin
      if (count == 8'd0) begin
        max_code[we_e] <= '1;
      end else begin
        min_code[we_e] <= bc[15:0];
        value_offset[we_e] <= bo[7:0];
        max_code[we_e] <= (last > 18'h0FFFF) ? 17'h0FFFF : last[16:0];
      end
      build_code[cls] <= 17'((bc + 17'(count)) << 1);
      build_offset[cls] <= bo + 9'(count);
    end
  end

  assign lk_max = max_code[{lk_cls, lk_len}];
  assign lk_min = min_code[{lk_cls, lk_len}];
  assign lk_off = value_offset[{lk_cls, lk_len}];
endmodule
`default_nettype wire

// File: rtl/jhd_checker.sv
`default_nettype none
module jhd_assert (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] position,
  input wire logic [15:0] coefficient,
  input wire logic       end_of_block,
  input wire logic       code_error
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(position))
    else $error("output changed while stalled");
  a_err_eob: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_error |-> end_of_block && position == 6'd0)
    else $error("error result not an end marker");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_error |-> coefficient == 16'd0)
    else $error("error result carries data");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule
bind jpeg_huffman_block_decoder_core jhd_assert u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .position(position),
  .coefficient(coefficient), .end_of_block(end_of_block), .code_error(code_error)
);
`default_nettype wire

// File: bench/jhd_checker.sv
`default_nettype none
module jhd_checker
  import jhd_pkg::*;
#(
  parameter int SYMBOL_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  func,
  input  wire logic        table_class,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [5:0]  position,
  input  wire logic [15:0] coefficient,
  input  wire logic        end_of_block,
  input  wire logic        code_error,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // code limit tables, entry = class*16 + length-1; upper limit -1 means empty
  int          lim_max[2*MAX_CODE_LEN];
  logic [15:0] lim_min[2*MAX_CODE_LEN];
  logic [7:0]  lim_off[2*MAX_CODE_LEN];
  logic [7:0]  sym_mem[512];
  logic [16:0] bld_code[2];
  logic [8:0]  bld_off[2];
  logic [15:0] dc_pred;
  logic [15:0] code_acc;
  logic [4:0]  code_len;
  logic [3:0]  mag_size;
  logic [15:0] mag_acc;
  logic [6:0]  blk_pos;
  logic [1:0]  phase;
  logic        ff_seen;
  result_t     coef_q[$];

  function automatic logic [15:0] sign_magnitude(input logic [15:0] bits,
                                                 input logic [3:0] size);
    logic [16:0] span;
    span = (17'd1 << size) - 17'd1;
    return bits[size - 1] ? bits : 16'(bits - span[15:0]);
  endfunction

  task automatic push_coef(input logic [5:0] pos, input logic [15:0] coef,
                           input logic eob, input logic err);
    result_t r;
    r.position = pos;
    r.coefficient = coef;
    r.end_of_block = eob;
    r.code_error = err;
    coef_q.push_back(r);
  endtask

  task automatic start_block();
    blk_pos = 0;
    phase = PH_DC_CODE;
    code_acc = 0;
    code_len = 0;
    mag_size = 0;
    mag_acc = 0;
  endtask

  task automatic decode_bit(input logic b);
    int          e;
    logic        t;
    logic [7:0]  sym;
    logic [5:0]  pos;
    logic [15:0] coef;
    if (phase == PH_DC_CODE || phase == PH_AC_CODE) begin
      t = (phase == PH_AC_CODE);
      code_acc = {code_acc[14:0], b};
      code_len = code_len + 5'd1;
      e = t * MAX_CODE_LEN + code_len - 1;
      if (int'(code_acc) > lim_max[e]) begin
        if (code_len >= MAX_CODE_LEN) begin
          start_block();
          push_coef(0, 0, 1, 1);
        end
        return;
      end
      sym = sym_mem[t * 256 + 8'(lim_off[e] + code_acc - lim_min[e])];
      code_acc = 0;
      code_len = 0;
      mag_acc = 0;
      if (!t) begin
        mag_size = sym[3:0];
        if (mag_size == 0) begin
          phase = PH_AC_CODE;
          blk_pos = 1;
          push_coef(0, dc_pred, 0, 0);
        end else begin
          phase = PH_DC_MAG;
        end
      end else if (sym[3:0] != 0) begin
        blk_pos = blk_pos + sym[7:4];
        if (blk_pos >= BLOCK_COEFFS) begin
          start_block();
          push_coef(0, 0, 1, 0);
        end else begin
          mag_size = sym[3:0];
          phase = PH_AC_MAG;
        end
      end else if (sym[7:4] == 4'd15) begin
        // zero run of 16
        blk_pos = blk_pos + 7'd16;
        if (blk_pos >= BLOCK_COEFFS) begin
          start_block();
          push_coef(0, 0, 1, 0);
        end
      end else begin
        start_block();
        push_coef(0, 0, 1, 0);
      end
      return;
    end
    mag_acc = {mag_acc[14:0], b};
    code_len = code_len + 5'd1;
    if (code_len < mag_size) return;
    code_len = 0;
    if (phase == PH_DC_MAG) begin
      dc_pred = dc_pred + sign_magnitude(mag_acc, mag_size);
      phase = PH_AC_CODE;
      blk_pos = 1;
      mag_acc = 0;
      push_coef(0, dc_pred, 0, 0);
    end else begin
      pos = blk_pos[5:0];
      coef = sign_magnitude(mag_acc, mag_size);
      mag_acc = 0;
      blk_pos = blk_pos + 7'd1;
      if (blk_pos >= BLOCK_COEFFS) begin
        start_block();
        push_coef(pos, coef, 1, 0);
      end else begin
        phase = PH_AC_CODE;
        push_coef(pos, coef, 0, 0);
      end
    end
  endtask

  task automatic apply_item(input logic [1:0] f, input logic t, input logic [7:0] idx,
                            input logic [7:0] val);
    int e;
    int last;
    case (f)
      FUNC_COUNT: begin
        if (idx < MAX_CODE_LEN) begin
          if (idx == 0) begin
            bld_code[t] = 0;
            bld_off[t] = 0;
          end
          e = t * MAX_CODE_LEN + idx;
          if (val == 0) begin
            lim_max[e] = -1;
          end else begin
            lim_min[e] = bld_code[t][15:0];
            lim_off[e] = bld_off[t][7:0];
            last = int'(bld_code[t]) + val - 1;
            lim_max[e] = (last > 16'hFFFF) ? 16'hFFFF : last;
          end
          bld_code[t] = 17'((bld_code[t] + val) << 1);
          bld_off[t] = 9'(bld_off[t] + val);
        end
      end
      FUNC_SYMBOL: begin
        if (idx < SYMBOL_SLOTS) sym_mem[t * 256 + idx] = val;
      end
      FUNC_RESTART: begin
        dc_pred = 0;
        ff_seen = 0;
        start_block();
      end
      default: begin
        // stuffed zero after 0xFF is dropped
        if (ff_seen) begin
          ff_seen = 0;
          if (val == 0) return;
        end
        if (val == 8'hFF) ff_seen = 1;
        for (int b = 7; b >= 0; b--) decode_bit(val[b]);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < 2 * MAX_CODE_LEN; i++) begin
        lim_max[i] = -1;
        lim_min[i] = 0;
        lim_off[i] = 0;
      end
      bld_code[0] = 0;
      bld_code[1] = 0;
      bld_off[0] = 0;
      bld_off[1] = 0;
      dc_pred = 0;
      ff_seen = 0;
      start_block();
      coef_q.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (coef_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result pos=%0d coef=%0d eob=%0b err=%0b", $realtime,
                     position, $signed(coefficient), end_of_block, code_error);
        end else begin
          want = coef_q.pop_front();
          if (position !== want.position || coefficient !== want.coefficient ||
              end_of_block !== want.end_of_block || code_error !== want.code_error) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp pos=%0d coef=%0d eob=%0b err=%0b, got %0d %0d %0b %0b",
                       $realtime, want.position, $signed(want.coefficient),
                       want.end_of_block, want.code_error, position, $signed(coefficient),
                       end_of_block, code_error);
          end
        end
      end
      if (in_valid && in_ready) apply_item(func, table_class, entry_index, value);
    end
    pending = coef_q.size();
  end
endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
  import jhd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic        table_class;
  logic [7:0]  entry_index;
  logic [7:0]  value;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  position;
  logic signed [15:0] coefficient;
  logic        end_of_block;
  logic        code_error;
  int          errors;
  int          pending;
  int          burst_left;
  int          idle_cycles;
  logic        squeeze;

  jpeg_huffman_block_decoder_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .table_class(table_class), .entry_index(entry_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .coefficient(coefficient),
    .end_of_block(end_of_block), .code_error(code_error)
  );

  jhd_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .table_class(table_class), .entry_index(entry_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .position(position), .coefficient(coefficient),
    .end_of_block(end_of_block), .code_error(code_error),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    rst = 1;
    in_valid = 0;
    func = FUNC_RESTART;
    table_class = 0;
    entry_index = 0;
    value = 0;
    out_ready = 0;
    squeeze = 0;
    burst_left = 0;
  end

  always #5 clk = ~clk;

  // sender: bursts of random length separated by random gaps
  task automatic send(input logic [1:0] f, input logic t, input logic [7:0] idx,
                      input logic [7:0] val);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    func <= f;
    table_class <= t;
    entry_index <= idx;
    value <= val;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // random canonical code lengths that never oversubscribe the code space
  task automatic pick_counts(output int cnt[16], input int maxper);
    int code;
    int room;
    code = 0;
    for (int l = 0; l < 16; l++) begin
      room = (1 << (l + 1)) - code;
      cnt[l] = $urandom_range(0, (room < maxper) ? room : maxper);
      code = (code + cnt[l]) * 2;
    end
  endtask

  // counts in length order, then a symbol for every slot the codes reach
  task automatic load_table(input logic t, input int cnt[16]);
    int nsym;
    logic [7:0] sym;
    nsym = 0;
    for (int l = 0; l < 16; l++) begin
      send(FUNC_COUNT, t, 8'(l), 8'(cnt[l]));
      nsym += cnt[l];
    end
    for (int s = 0; s < nsym; s++) begin
      case ($urandom_range(0, 9))
        0: sym = t ? 8'h00 : 8'($urandom_range(0, 255));
        1: sym = t ? 8'hF0 : 8'h00;
        default: sym = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))};
      endcase
      if (t && $urandom_range(0, 3) != 0) sym[3:0] = 4'($urandom_range(1, 6));
      send(FUNC_SYMBOL, t, 8'(s), sym);
    end
  endtask

  task automatic load_complete_tables();
    int dc_cnt[16];
    int ac_cnt[16];
    dc_cnt = '{0, 3, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    ac_cnt = '{0, 2, 2, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    load_table(0, dc_cnt);
    load_table(1, ac_cnt);
  endtask

  // receiver: changing stall pattern, one long hold when asked
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        if (squeeze) begin
          squeeze = 0;
          out_ready <= 0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_ready <= 1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int cnt[16];
    int pick;
    logic [7:0] b;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: ignored count index, top symbol slot, empty tables
    send(FUNC_COUNT, 1, 8'd200, 8'd7);
    send(FUNC_SYMBOL, 0, 8'd255, 8'hFF);
    send(FUNC_SYMBOL, 1, 8'd255, 8'h00);
    send(FUNC_DATA, 0, 8'd0, 8'h5A);
    send(FUNC_DATA, 0, 8'd0, 8'hC3);
    send(FUNC_RESTART, 0, 8'd0, 8'd0);
    load_complete_tables();
    send(FUNC_DATA, 0, 8'd0, 8'h00);
    send(FUNC_DATA, 0, 8'd0, 8'hFF);
    send(FUNC_DATA, 0, 8'd0, 8'h00);
    send(FUNC_DATA, 0, 8'd0, 8'hFF);
    send(FUNC_DATA, 0, 8'd0, 8'hFF);
    send(FUNC_DATA, 0, 8'd0, 8'h12);
    send(FUNC_DATA, 0, 8'd0, 8'hAA);
    send(FUNC_RESTART, 1, 8'd0, 8'd0);
    send(FUNC_DATA, 0, 8'd0, 8'h55);
    // only 16-bit codes
    cnt = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3};
    load_table(0, cnt);
    repeat (4) send(FUNC_DATA, 0, 8'd0, 8'($urandom_range(0, 255)));
    send(FUNC_DATA, 0, 8'd0, 8'h00);
    send(FUNC_DATA, 0, 8'd0, 8'h00);
    load_complete_tables();

    // random: mostly complete tables, so every bit string decodes
    for (int n = 0; n < 100; n++) begin
      if (n == 30) squeeze = 1;
      pick = $urandom_range(0, 39);
      if (pick == 0) begin
        send(FUNC_RESTART, 0, 8'd0, 8'd0);
      end else if (pick == 1) begin
        pick_counts(cnt, 2);
        load_table(1'($urandom_range(0, 1)), cnt);
      end else if (pick == 2) begin
        load_complete_tables();
      end
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) b = 8'hFF;
      send(FUNC_DATA, 0, 8'd0, b);
      if (b == 8'hFF && $urandom_range(0, 1)) send(FUNC_DATA, 0, 8'd0, 8'h00);
    end
    @(negedge clk);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
